/* hdl/sts_pkg.sv */
// Shared constants, types and operation codes for the sorted table block.
// No dependencies; every other file of the block uses this package.
package sts_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int KEY_W       = 32;
  localparam int OP_W        = 2;
  localparam int FIELD_W     = 7;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [OP_W-1:0] {
    OP_SEARCH = 2'd0,
    OP_INSERT = 2'd1,
    OP_CLEAR  = 2'd2
  } op_t;

  typedef struct packed {
    logic write;
    logic clear;
  } cell_ctl_t;

endpackage

/* hdl/sts_ifs.sv */
// Valid/ready channel interfaces for request and result transactions.
// Depends on sts_pkg for field widths.
interface sts_req_if;
  logic                               valid;
  logic                               ready;
  logic [sts_pkg::OP_W-1:0]           operation;
  logic signed [sts_pkg::KEY_W-1:0]   key_value;

  modport source (output valid, output operation, output key_value, input ready);
  modport sink   (input valid, input operation, input key_value, output ready);
endinterface

interface sts_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          found;
  logic [sts_pkg::FIELD_W-1:0]   position;
  logic                          status;
  logic [sts_pkg::FIELD_W-1:0]   entry_count;

  modport source (output valid, output found, output position, output status,
                  output entry_count, input ready);
  modport sink   (input valid, input found, input position, input status,
                  input entry_count, output ready);
endinterface

/* hdl/sts_cell.sv */
// One slot of the sorted table: holds an entry and its valid flag, compares
// against the key and shifts from its lower neighbor on insert. Uses sts_pkg.
module sts_cell (
  input  logic                         clk,
  input  logic                         rst_n,
  input  sts_pkg::cell_ctl_t           ctl,
  input  logic signed [sts_pkg::KEY_W-1:0] key,
  input  logic                         prev_less,
  input  logic signed [sts_pkg::KEY_W-1:0] prev_entry,
  input  logic                         prev_valid,
  output logic signed [sts_pkg::KEY_W-1:0] entry,
  output logic                         valid,
  output logic                         less,
  output logic                         eq,
  output logic                         is_pos
);
  import sts_pkg::*;

  logic signed [KEY_W-1:0] entry_r;
  logic                    valid_r;

  assign less   = valid_r && (entry_r < key);
  assign eq     = valid_r && (entry_r == key);
  assign is_pos = !less && prev_less;
  assign entry  = entry_r;
  assign valid  = valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctl.clear) begin
      valid_r <= 1'b0;
    end else if (ctl.write && !less) begin
      valid_r <= is_pos ? 1'b1 : prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.write && !less) begin
      entry_r <= is_pos ? key : prev_entry;
    end
  end

endmodule

/* hdl/sorted_table_search_insert.sv */
// Sorted table with search and ordered insert.
// Channels: in_ch takes request transactions (operation, key_value) and
// out_ch gives one result transaction (found, position, status,
// entry_count) for each request; both use valid/ready.
// A request is latched on acceptance, and in the next cycle every slot of
// the row compares itself with the key at once; the lower-bound position
// is the slot where the compare result turns over, and an insert shifts
// each larger entry into its upper neighbor on that same edge.
// The request is executed in S_EXEC and its result is registered at the end
// of that state; no new request is taken while the compare-and-shift pass runs.
// Search returns the lower-bound position and whether that entry matches.
// Insert into a full table leaves it unchanged and reports status 1.
// Clear empties the table; operation code three changes nothing.
// Reset (synchronous, active low) empties the table and drops any result.
// A stalled receiver holds the result; no new request is taken until the
// held result is taken. Depends on sts_pkg, sts_ifs and sts_cell.
module sorted_table_search_insert (
  input  logic       clk,
  input  logic       rst_n,
  sts_req_if.sink    in_ch,
  sts_rsp_if.source  out_ch
);
  import sts_pkg::*;

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t                  state_r;
  logic [OP_W-1:0]         op_r;
  logic signed [KEY_W-1:0] key_r;
  logic [CNT_W-1:0]        count_r;
  logic                    out_valid_r;
  logic                    found_r;
  logic [FIELD_W-1:0]      position_r;
  logic                    status_r;
  logic [FIELD_W-1:0]      entry_count_r;

  logic signed [KEY_W-1:0] entry_w [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0]  valid_w;
  logic [TABLE_DEPTH-1:0]  less_w;
  logic [TABLE_DEPTH-1:0]  eq_w;
  logic [TABLE_DEPTH-1:0]  pos_w;

  cell_ctl_t               ctl;
  logic                    full;
  logic                    accept;
  logic [CNT_W-1:0]        pos_enc;
  logic                    hit;
  logic                    res_found;
  logic [CNT_W-1:0]        res_pos;
  logic                    res_status;
  logic [CNT_W-1:0]        count_nxt;

  assign full       = (count_r == CNT_W'(TABLE_DEPTH));
  assign in_ch.ready = (state_r == S_IDLE) && (!out_valid_r || out_ch.ready);
  assign accept     = in_ch.valid && in_ch.ready;

  assign ctl.write = (state_r == S_EXEC) && (op_r == OP_INSERT) && !full;
  assign ctl.clear = (state_r == S_EXEC) && (op_r == OP_CLEAR);

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      sts_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .key        (key_r),
        .prev_less  (1'b1),
        .prev_entry (key_r),
        .prev_valid (1'b0),
        .entry      (entry_w[i]),
        .valid      (valid_w[i]),
        .less       (less_w[i]),
        .eq         (eq_w[i]),
        .is_pos     (pos_w[i])
      );
    end else begin : g_rest
      sts_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .key        (key_r),
        .prev_less  (less_w[i-1]),
        .prev_entry (entry_w[i-1]),
        .prev_valid (valid_w[i-1]),
        .entry      (entry_w[i]),
        .valid      (valid_w[i]),
        .less       (less_w[i]),
        .eq         (eq_w[i]),
        .is_pos     (pos_w[i])
      );
    end
  end

  always_comb begin
    pos_enc = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (pos_w[i]) pos_enc = pos_enc | CNT_W'(i);
    end
    if (less_w[TABLE_DEPTH-1]) pos_enc = CNT_W'(TABLE_DEPTH);
    hit = |(pos_w & eq_w);
  end

  always_comb begin
    res_found  = 1'b0;
    res_pos    = '0;
    res_status = 1'b0;
    count_nxt  = count_r;
    case (op_r)
      OP_SEARCH: begin
        res_found = hit;
        res_pos   = pos_enc;
      end
      OP_INSERT: begin
        res_found = hit;
        res_pos   = pos_enc;
        if (full) begin
          res_status = 1'b1;
        end else begin
          count_nxt = count_r + CNT_W'(1);
        end
      end
      OP_CLEAR: begin
        count_nxt = '0;
      end
      default: begin
        count_nxt = count_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (out_valid_r && out_ch.ready) out_valid_r <= 1'b0;
          if (accept) state_r <= S_EXEC;
        end
        S_EXEC: begin
          count_r     <= count_nxt;
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= in_ch.operation;
      key_r <= in_ch.key_value;
    end
    if (state_r == S_EXEC) begin
      found_r       <= res_found;
      position_r    <= FIELD_W'(res_pos);
      status_r      <= res_status;
      entry_count_r <= FIELD_W'(count_nxt);
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.found       = found_r;
  assign out_ch.position    = position_r;
  assign out_ch.status      = status_r;
  assign out_ch.entry_count = entry_count_r;

endmodule
